>>> rtl/multi_channel_alarm_timer_defines.svh
// ----------------------------------------------------------------------------
// Multi-channel alarm timer assertion macros
// Concurrent assertion wrappers shared by the alarm timer RTL. Simulation
// builds get the checks; synthesis builds get empty bodies.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_ALARM_TIMER_DEFINES_SVH
`define MULTI_CHANNEL_ALARM_TIMER_DEFINES_SVH

`ifndef SYNTHESIS

`define MCAT_ASSERT(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

`define MCAT_ASSERT_ALWAYS(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);

`else

`define MCAT_ASSERT(label, clk_sig, rst_sig, prop, msg)

`define MCAT_ASSERT_ALWAYS(label, clk_sig, prop, msg)

`endif

`endif

>>> rtl/mcat_pkg.sv
// ----------------------------------------------------------------------------
// Multi-channel alarm timer package
// Channel count, derived widths, command and status codes, and the pick
// result shared between the top level and the pending picker.
// ----------------------------------------------------------------------------
package mcat_pkg;

  localparam int NUM_ALARMS  = 16;
  localparam int ALARM_IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
  localparam int TICK_CNT_W  = $clog2(NUM_ALARMS + 1);
  localparam int MASK_OUT_W  = 16;
  localparam int MASK_PAD_W  = (NUM_ALARMS > MASK_OUT_W) ? NUM_ALARMS : MASK_OUT_W;

  localparam logic [6:0] ID_LIMIT = 7'(NUM_ALARMS);

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_CANCEL  = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_SERVICE = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BAD_ID = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef struct packed {
    logic                   found;
    logic [ALARM_IDX_W-1:0] idx;
  } pick_t;

endpackage

>>> rtl/mcat_pick.sv
// ----------------------------------------------------------------------------
// Pending channel picker
// Priority encoder that selects the highest-numbered pending channel.
// ----------------------------------------------------------------------------
module mcat_pick (
  input  logic [mcat_pkg::NUM_ALARMS-1:0] pend,
  output mcat_pkg::pick_t                 pick
);

  always_comb begin
    pick.found = 1'b0;
    pick.idx   = '0;
    for (int k = 0; k < mcat_pkg::NUM_ALARMS; k++) begin
      if (pend[k]) begin
        pick.found = 1'b1;
        pick.idx   = mcat_pkg::ALARM_IDX_W'(k);
      end
    end
  end

endmodule

>>> rtl/multi_channel_alarm_timer.sv
// ----------------------------------------------------------------------------
// Multi-channel alarm timer
// Bank of alarm channels with tick, start, cancel, read and service commands.
//
// Usage: one command beat enters on in_valid/in_ready (opcode, chan_id,
// period, periodic); exactly one result beat leaves on out_valid/out_ready
// (status, remaining, serviced_id, serviced_valid, pending_any, active_bits,
// pending_bits). Counts and periods live in two synchronous memories, each
// with one read and one write port and a registered read; active,
// pending and mode bits are flip-flops.
// From accept to out_valid: start, cancel and rejected commands go straight
// to the finish state; read and service pass through their own state first;
// tick first runs the count memory sweep, which reads one channel per cycle
// and writes each active nonzero count back, decremented, in the next cycle.
// One command is in flight at a time and the next is taken the cycle after
// the result loads.
// The result sits in an output register; a new command is accepted while it
// waits. If the receiver stalls, the next result holds in the finish state
// until the output register frees up.
// Reset clears all masks and the count valid bits, so unstarted channels
// read as zero; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
`include "multi_channel_alarm_timer_defines.svh"

module multi_channel_alarm_timer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [5:0]  chan_id,
  input  logic [31:0] period,
  input  logic        periodic,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] remaining,
  output logic [5:0]  serviced_id,
  output logic        serviced_valid,
  output logic        pending_any,
  output logic [15:0] active_bits,
  output logic [15:0] pending_bits
);

  localparam int N    = mcat_pkg::NUM_ALARMS;
  localparam int IW   = mcat_pkg::ALARM_IDX_W;
  localparam int TW   = mcat_pkg::TICK_CNT_W;
  localparam int PADW = mcat_pkg::MASK_PAD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_READ,
    S_SVC,
    S_DONE
  } state_t;

  state_t           state;
  logic [TW-1:0]    tick_cnt;
  logic             s1_vld;
  logic [IW-1:0]    s1_idx;
  logic [IW-1:0]    req_idx;

  logic [N-1:0]     active;
  logic [N-1:0]     pending;
  logic [N-1:0]     mode;
  logic [N-1:0]     cnt_vld;

  logic [1:0]       res_status;
  logic [31:0]      res_remaining;
  logic [5:0]       res_sid;
  logic             res_sval;

  logic [31:0]      cnt_mem [N];
  logic [31:0]      per_mem [N];
  logic [31:0]      cnt_rdata;
  logic [31:0]      per_rdata;

  logic             accept;
  logic             id_ok;
  logic [IW-1:0]    id_idx;
  logic             tick_issue;
  logic [31:0]      tick_val;
  logic [31:0]      tick_dec;
  logic             tick_hit;
  logic [IW-1:0]    cnt_rd_addr;
  logic             cnt_we;
  logic [IW-1:0]    cnt_wr_addr;
  logic [31:0]      cnt_wdata;
  logic             per_we;
  logic             out_load;
  logic [PADW-1:0]  active_pad;
  logic [PADW-1:0]  pending_pad;
  mcat_pkg::pick_t  pick;

  mcat_pick u_pick (
    .pend (pending),
    .pick (pick)
  );

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign id_ok       = ({1'b0, chan_id} < mcat_pkg::ID_LIMIT);
  assign id_idx      = chan_id[IW-1:0];
  assign tick_issue  = (state == S_TICK) && (tick_cnt < TW'(N));
  assign tick_val    = cnt_vld[s1_idx] ? cnt_rdata : 32'd0;
  assign tick_dec    = tick_val - 32'd1;
  assign tick_hit    = (state == S_TICK) && s1_vld && active[s1_idx] && (tick_val != 32'd0);
  assign cnt_rd_addr = tick_issue ? tick_cnt[IW-1:0] : id_idx;
  assign per_we      = accept && (opcode == mcat_pkg::OP_START) && id_ok;
  assign out_load    = (state == S_DONE) && (!out_valid || out_ready);
  assign active_pad  = PADW'(active);
  assign pending_pad = PADW'(pending);

  always_comb begin
    cnt_we      = 1'b0;
    cnt_wr_addr = id_idx;
    cnt_wdata   = period;
    priority if (tick_hit) begin
      cnt_we      = 1'b1;
      cnt_wr_addr = s1_idx;
      cnt_wdata   = tick_dec;
    end else if (per_we) begin
      cnt_we      = 1'b1;
    end else if (accept && (opcode == mcat_pkg::OP_CANCEL) && id_ok && active[id_idx]) begin
      cnt_we      = 1'b1;
      cnt_wdata   = 32'd0;
    end else if ((state == S_SVC) && mode[req_idx]) begin
      cnt_we      = 1'b1;
      cnt_wr_addr = req_idx;
      cnt_wdata   = per_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wr_addr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[cnt_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (per_we) begin
      per_mem[id_idx] <= period;
    end
    per_rdata <= per_mem[pick.idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tick_cnt  <= '0;
      s1_vld    <= 1'b0;
      active    <= '0;
      pending   <= '0;
      mode      <= '0;
      cnt_vld   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (tick_hit && (tick_dec == 32'd0)) begin
        pending[s1_idx] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_remaining <= 32'd0;
            res_sid       <= 6'd0;
            res_sval      <= 1'b0;
            unique case (opcode)
              mcat_pkg::OP_TICK: begin
                res_status <= mcat_pkg::ST_OK;
                tick_cnt   <= '0;
                s1_vld     <= 1'b0;
                state      <= S_TICK;
              end
              mcat_pkg::OP_START: begin
                state <= S_DONE;
                if (!id_ok) begin
                  res_status <= mcat_pkg::ST_BAD_ID;
                end else begin
                  res_status      <= mcat_pkg::ST_OK;
                  mode[id_idx]    <= periodic;
                  active[id_idx]  <= 1'b1;
                  cnt_vld[id_idx] <= 1'b1;
                end
              end
              mcat_pkg::OP_CANCEL: begin
                state <= S_DONE;
                if (!id_ok) begin
                  res_status <= mcat_pkg::ST_BAD_ID;
                end else if (!active[id_idx]) begin
                  res_status <= mcat_pkg::ST_REJECT;
                end else begin
                  res_status     <= mcat_pkg::ST_OK;
                  active[id_idx] <= 1'b0;
                end
              end
              mcat_pkg::OP_READ: begin
                if (!id_ok) begin
                  res_status <= mcat_pkg::ST_BAD_ID;
                  state      <= S_DONE;
                end else begin
                  res_status <= mcat_pkg::ST_OK;
                  req_idx    <= id_idx;
                  state      <= S_READ;
                end
              end
              mcat_pkg::OP_SERVICE: begin
                if (!pick.found) begin
                  res_status <= mcat_pkg::ST_REJECT;
                  state      <= S_DONE;
                end else begin
                  res_status <= mcat_pkg::ST_OK;
                  req_idx    <= pick.idx;
                  state      <= S_SVC;
                end
              end
              default: begin
                res_status <= mcat_pkg::ST_REJECT;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_TICK: begin
          s1_vld <= tick_issue;
          s1_idx <= tick_cnt[IW-1:0];
          if (tick_issue) begin
            tick_cnt <= tick_cnt + 1'b1;
          end else begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          res_remaining <= cnt_vld[req_idx] ? cnt_rdata : 32'd0;
          state         <= S_DONE;
        end
        S_SVC: begin
          active[req_idx]  <= mode[req_idx];
          pending[req_idx] <= 1'b0;
          res_sid          <= 6'(req_idx);
          res_sval         <= 1'b1;
          state            <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            status         <= res_status;
            remaining      <= res_remaining;
            serviced_id    <= res_sid;
            serviced_valid <= res_sval;
            pending_any    <= |pending;
            active_bits    <= active_pad[15:0];
            pending_bits   <= pending_pad[15:0];
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MCAT_ASSERT(a_busy, clk, rst, (state != S_IDLE) |-> !in_ready, "input taken while busy")
  `MCAT_ASSERT(a_sweep, clk, rst, tick_hit && tick_issue |-> cnt_wr_addr != cnt_rd_addr, "sweep clash")
  `MCAT_ASSERT(a_svc_ok, clk, rst, out_valid && serviced_valid |-> status == mcat_pkg::ST_OK, "svc status")
  `MCAT_ASSERT(a_pend_any, clk, rst, out_valid && |pending_bits |-> pending_any, "pending_any low")
  `MCAT_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> (state == S_IDLE) && !out_valid, "no idle after reset")

endmodule

>>> tb/sv/multi_channel_alarm_timer_tb.sv
// ----------------------------------------------------------------------------
// Multi-channel alarm timer testbench
// Drives tick, start, cancel, read and service commands, plus bad ids and
// unused opcodes, through the valid/ready command channel. A behavioral
// copy of the alarm bank predicts every reply beat, and each reply is checked
// field by field against the oldest prediction. Both sides idle at random;
// the reply side also holds off for a long stretch to back up the block.
// ----------------------------------------------------------------------------
module multi_channel_alarm_timer_tb;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int IDLE_PCT    = 35;
  localparam int HOLD_CYCLES = 120;
  localparam int STUCK_LIMIT = 2000;
  localparam int SETTLE      = mcat_pkg::NUM_ALARMS + 8;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] remaining;
    logic [5:0]  serviced_id;
    logic        serviced_valid;
    logic        pending_any;
    logic [15:0] active_bits;
    logic [15:0] pending_bits;
  } timer_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  opcode = mcat_pkg::OP_TICK;
  logic [5:0]  chan_id = '0;
  logic [31:0] period = '0;
  logic        periodic = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] remaining;
  logic [5:0]  serviced_id;
  logic        serviced_valid;
  logic        pending_any;
  logic [15:0] active_bits;
  logic [15:0] pending_bits;

  logic [31:0]                     count_q [mcat_pkg::NUM_ALARMS];
  logic [31:0]                     reload_q [mcat_pkg::NUM_ALARMS];
  logic                            mode_q [mcat_pkg::NUM_ALARMS];
  logic [mcat_pkg::NUM_ALARMS-1:0] act_mask = '0;
  logic [mcat_pkg::NUM_ALARMS-1:0] pend_mask = '0;

  timer_reply_t awaited_replies[$];

  bit no_idle  = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stuck_cycles = 0;
  int errors = 0;
  int cmds_sent = 0;
  int replies_checked = 0;
  int alarms_serviced = 0;
  int ticks_sent = 0;
  int backpressure_stalls = 0;

  multi_channel_alarm_timer u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .chan_id        (chan_id),
    .period         (period),
    .periodic       (periodic),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .remaining      (remaining),
    .serviced_id    (serviced_id),
    .serviced_valid (serviced_valid),
    .pending_any    (pending_any),
    .active_bits    (active_bits),
    .pending_bits   (pending_bits)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    for (int ch = 0; ch < mcat_pkg::NUM_ALARMS; ch++) begin
      count_q[ch]  = '0;
      reload_q[ch] = '0;
      mode_q[ch]   = 1'b0;
    end
  end

  function automatic timer_reply_t apply_timer_cmd(logic [2:0] op, logic [5:0] id,
                                                   logic [31:0] per, logic mode);
    timer_reply_t r;
    bit           id_ok;
    int           found;
    r = '0;
    id_ok = int'(id) < mcat_pkg::NUM_ALARMS;
    found = -1;
    case (op)
      mcat_pkg::OP_TICK: begin
        for (int ch = 0; ch < mcat_pkg::NUM_ALARMS; ch++) begin
          if (act_mask[ch] && count_q[ch] != 0) begin
            count_q[ch] = count_q[ch] - 1;
            if (count_q[ch] == 0) pend_mask[ch] = 1'b1;
          end
        end
      end
      mcat_pkg::OP_START: begin
        if (!id_ok) begin
          r.status = mcat_pkg::ST_BAD_ID;
        end else begin
          reload_q[id] = per;
          mode_q[id]   = mode;
          count_q[id]  = per;
          act_mask[id] = 1'b1;
        end
      end
      mcat_pkg::OP_CANCEL: begin
        if (!id_ok) begin
          r.status = mcat_pkg::ST_BAD_ID;
        end else if (!act_mask[id]) begin
          r.status = mcat_pkg::ST_REJECT;
        end else begin
          count_q[id]  = '0;
          act_mask[id] = 1'b0;
        end
      end
      mcat_pkg::OP_READ: begin
        if (!id_ok) r.status = mcat_pkg::ST_BAD_ID;
        else r.remaining = count_q[id];
      end
      mcat_pkg::OP_SERVICE: begin
        for (int ch = mcat_pkg::NUM_ALARMS - 1; ch >= 0 && found < 0; ch--) begin
          if (pend_mask[ch]) found = ch;
        end
        if (found < 0) begin
          r.status = mcat_pkg::ST_REJECT;
        end else begin
          if (mode_q[found]) begin
            count_q[found]  = reload_q[found];
            act_mask[found] = 1'b1;
          end else begin
            act_mask[found] = 1'b0;
          end
          pend_mask[found] = 1'b0;
          r.serviced_id    = 6'(found);
          r.serviced_valid = 1'b1;
        end
      end
      default: begin
        r.status = mcat_pkg::ST_REJECT;
      end
    endcase
    r.pending_any  = |pend_mask;
    r.active_bits  = mcat_pkg::MASK_OUT_W'(act_mask);
    r.pending_bits = mcat_pkg::MASK_OUT_W'(pend_mask);
    return r;
  endfunction

  task automatic report_fail(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v)
      report_fail($sformatf("reply %0d %s expected %h got %h", replies_checked, name,
                            exp_v, got_v));
  endtask

  // Reply checker: compare each accepted reply beat with the oldest prediction.
  always @(posedge clk) begin
    timer_reply_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        report_fail("reply beat with no command outstanding");
      end else begin
        exp_r = awaited_replies.pop_front();
        check_field("status", 32'(exp_r.status), 32'(status));
        check_field("remaining", exp_r.remaining, remaining);
        check_field("serviced_id", 32'(exp_r.serviced_id), 32'(serviced_id));
        check_field("serviced_valid", 32'(exp_r.serviced_valid), 32'(serviced_valid));
        check_field("pending_any", 32'(exp_r.pending_any), 32'(pending_any));
        check_field("active_bits", 32'(exp_r.active_bits), 32'(active_bits));
        check_field("pending_bits", 32'(exp_r.pending_bits), 32'(pending_bits));
        if (exp_r.serviced_valid) alarms_serviced++;
        replies_checked++;
      end
    end
  end

  // Reply side ready: random stalls, quiet stretches and a long hold-off.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_ready && hold_left > 0) backpressure_stalls++;
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STUCK_LIMIT);
      $display("** multi_channel_alarm_timer: FAILED **");
      $finish;
    end
  end

  task automatic send_cmd(logic [2:0] op, logic [5:0] id, logic [31:0] per, logic mode);
    int gap;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(0, 99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    chan_id  <= id;
    period   <= per;
    periodic <= mode;
    do @(posedge clk); while (!in_ready);
    awaited_replies.push_back(apply_timer_cmd(op, id, per, mode));
    cmds_sent++;
    if (op == mcat_pkg::OP_TICK) ticks_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_replies.size() != 0);
  endtask

  task automatic send_random_cmd();
    int          pick;
    int          psel;
    logic [31:0] per;
    pick = $urandom_range(0, 99);
    psel = $urandom_range(0, 9);
    per  = (psel < 7) ? 32'($urandom_range(1, 6)) : (psel == 7) ? 32'd0 : $urandom();
    if (pick < 32)
      send_cmd(mcat_pkg::OP_TICK, 6'($urandom_range(0, 63)), $urandom(), 1'($urandom()));
    else if (pick < 52)
      send_cmd(mcat_pkg::OP_START, 6'($urandom_range(0, mcat_pkg::NUM_ALARMS - 1)), per,
               1'($urandom()));
    else if (pick < 62)
      send_cmd(mcat_pkg::OP_CANCEL, 6'($urandom_range(0, mcat_pkg::NUM_ALARMS - 1)),
               $urandom(), 1'($urandom()));
    else if (pick < 72)
      send_cmd(mcat_pkg::OP_READ, 6'($urandom_range(0, mcat_pkg::NUM_ALARMS - 1)),
               $urandom(), 1'($urandom()));
    else if (pick < 86)
      send_cmd(mcat_pkg::OP_SERVICE, 6'($urandom_range(0, 63)), $urandom(),
               1'($urandom()));
    else
      send_cmd(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)), $urandom(),
               1'($urandom()));
  endtask

  task automatic test_idle_bank();
    send_cmd(mcat_pkg::OP_READ, 6'd0, 32'd0, 1'b0);
    send_cmd(mcat_pkg::OP_SERVICE, 6'd0, 32'd0, 1'b0);
    send_cmd(mcat_pkg::OP_CANCEL, 6'd3, 32'd0, 1'b0);
    send_cmd(mcat_pkg::OP_TICK, 6'd0, 32'd0, 1'b0);
  endtask

  task automatic test_bad_requests();
    send_cmd(mcat_pkg::OP_START, 6'(mcat_pkg::NUM_ALARMS), 32'hFFFF_FFFF, 1'b1);
    send_cmd(mcat_pkg::OP_CANCEL, 6'd63, 32'd0, 1'b0);
    send_cmd(mcat_pkg::OP_READ, 6'd40, 32'd0, 1'b0);
    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
      send_cmd(3'(op), 6'd1, 32'd5, 1'b1);
  endtask

  task automatic test_one_shot();
    send_cmd(mcat_pkg::OP_START, 6'(mcat_pkg::NUM_ALARMS - 1), 32'd2, 1'b0);
    send_cmd(mcat_pkg::OP_TICK, 6'd0, 32'd0, 1'b0);
    send_cmd(mcat_pkg::OP_TICK, 6'd0, 32'd0, 1'b0);
    send_cmd(mcat_pkg::OP_READ, 6'(mcat_pkg::NUM_ALARMS - 1), 32'd0, 1'b0);
    send_cmd(mcat_pkg::OP_SERVICE, 6'd0, 32'd0, 1'b0);
  endtask

  task automatic test_periodic_cancel();
    send_cmd(mcat_pkg::OP_START, 6'd0, 32'd1, 1'b1);
    send_cmd(mcat_pkg::OP_START, 6'd1, 32'd0, 1'b1);
    send_cmd(mcat_pkg::OP_TICK, 6'd0, 32'd0, 1'b0);
    send_cmd(mcat_pkg::OP_CANCEL, 6'd0, 32'd0, 1'b0);
    send_cmd(mcat_pkg::OP_SERVICE, 6'd0, 32'd0, 1'b0);
    send_cmd(mcat_pkg::OP_READ, 6'd0, 32'd0, 1'b0);
  endtask

  task automatic test_full_period();
    send_cmd(mcat_pkg::OP_START, 6'd7, 32'hFFFF_FFFF, 1'b1);
    send_cmd(mcat_pkg::OP_TICK, 6'd0, 32'd0, 1'b0);
    send_cmd(mcat_pkg::OP_READ, 6'd7, 32'd0, 1'b0);
    send_cmd(mcat_pkg::OP_CANCEL, 6'd7, 32'd0, 1'b0);
  endtask

  task automatic test_random_traffic(int n);
    repeat (n) send_random_cmd();
  endtask

  task automatic test_quiet_stretch(int n);
    no_idle = 1'b1;
    repeat (n) send_random_cmd();
    no_idle = 1'b0;
  endtask

  task automatic test_back_pressure(int n);
    hold_req = 1'b1;
    no_idle  = 1'b1;
    repeat (n) send_random_cmd();
    no_idle = 1'b0;
    wait_drained();
  endtask

  task automatic test_drain_pause(int n);
    for (int i = 0; i < n; i++) begin
      send_random_cmd();
      if (i % 25 == 24) wait_drained();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_bank();
    test_bad_requests();
    test_one_shot();
    test_periodic_cancel();
    test_full_period();
    test_random_traffic(375);
    test_quiet_stretch(120);
    test_back_pressure(30);
    test_drain_pause(100);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (awaited_replies.size() != 0)
      report_fail($sformatf("%0d replies never arrived", awaited_replies.size()));
    $display("run covered %0d commands (%0d ticks), %0d replies checked", cmds_sent,
             ticks_sent, replies_checked);
    $display("alarms serviced: %0d, input stalls under hold-off: %0d, mismatches: %0d",
             alarms_serviced, backpressure_stalls, errors);
    if (errors == 0) begin
      $display("** multi_channel_alarm_timer: PASSED **");
    end else begin
      $display("** multi_channel_alarm_timer: FAILED **");
    end
    $finish;
  end

endmodule
